/* hw/rtl/ohlc_pkg.sv */
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared types, constants and the session filter for the OHLC bar aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    localparam int TIME_W   = 12;
    localparam int DAY_W    = 27;
    localparam int PRICE_W  = 32;
    localparam int VOL_W    = 32;
    localparam int OI_W     = 32;
    localparam int SUM_W    = 48;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 240;

    localparam int QUEUE_DEPTH = 2;

    localparam logic MODE_COMMODITY = 1'b0;
    localparam logic MODE_FINANCIAL = 1'b1;

    // Commodity session bounds
    localparam logic [TIME_W-1:0] CMD_CLOSE     = 12'd1500;
    localparam logic [TIME_W-1:0] CMD_LUNCH_BEG = 12'd1130;
    localparam logic [TIME_W-1:0] CMD_LUNCH_END = 12'd1330;
    localparam logic [TIME_W-1:0] CMD_BREAK_BEG = 12'd1015;
    localparam logic [TIME_W-1:0] CMD_BREAK_END = 12'd1030;
    localparam logic [TIME_W-1:0] CMD_OPEN      = 12'd859;

    // Financial futures session bounds
    localparam logic [TIME_W-1:0] FIN_CLOSE     = 12'd1515;
    localparam logic [TIME_W-1:0] FIN_LUNCH_BEG = 12'd1130;
    localparam logic [TIME_W-1:0] FIN_LUNCH_END = 12'd1300;
    localparam logic [TIME_W-1:0] FIN_OPEN      = 12'd915;

    typedef struct packed {
        logic [OI_W-1:0]    open_interest;
        logic [VOL_W-1:0]   tick_volume;
        logic [PRICE_W-1:0] price;
        logic [DAY_W-1:0]   day_number;
    } tick_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic in_session(input logic [TIME_W-1:0] t, input logic mode);
        logic keep;
        begin
            keep = 1'b1;
            if (mode == MODE_FINANCIAL)
            begin
                if (t > FIN_CLOSE) keep = 1'b0;
                if (t >= FIN_LUNCH_BEG && t < FIN_LUNCH_END) keep = 1'b0;
                if (t < FIN_OPEN) keep = 1'b0;
            end
            else
            begin
                if (t > CMD_CLOSE) keep = 1'b0;
                if (t >= CMD_LUNCH_BEG && t < CMD_LUNCH_END) keep = 1'b0;
                if (t >= CMD_BREAK_BEG && t < CMD_BREAK_END) keep = 1'b0;
                if (t < CMD_OPEN) keep = 1'b0;
            end
            return keep;
        end
    endfunction

endpackage

/* hw/rtl/daily_ohlc_bar_aggregator.sv */
// ----------------------------------------------------------------------------
// daily_ohlc_bar_aggregator
// Builds a daily open/high/low/close bar from a stream of market ticks.
// ----------------------------------------------------------------------------
// Takes one tick request per clock while the queue is not full and returns
// the running daily bar for every tick that falls inside the trading
// sessions picked by session_mode (0 commodity, 1 financial futures); other
// ticks are dropped without a result. A tick goes through the session filter
// into a FIFO_DEPTH-entry queue, and the bar update pops one entry per cycle
// while the queue holds one and the output is free or taken, so the sustained
// rate is one tick per cycle while m_axis_tready is high. Popped ticks update
// the bar with a compare and 48-bit saturating add. tuser flags the first
// tick of a new day. Write session_mode only while no tick is in flight.
module daily_ohlc_bar_aggregator
    import ohlc_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic             cfg_wdata,       // session_mode
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // time_hhmm, day_number, price, tick_volume, open_interest
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // bar_day, bar_open, bar_high, bar_low, bar_close, bar_volume,
    // bar_open_interest
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser     // new_bar
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    tick_t   push_tick;
    tick_t   pop_tick;

    ohlc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push          (push),
        .push_tick     (push_tick)
    );

    ohlc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tick (push_tick),
        .pop       (pop),
        .pop_tick  (pop_tick),
        .q_stat    (q_stat)
    );

    ohlc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_tick      (pop_tick),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_pop_shows_bar: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("popped tick produced no bar");

    a_new_bar_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[58:27] == m_axis_tdata[90:59]) &&
            (m_axis_tdata[58:27] == m_axis_tdata[122:91]) &&
            (m_axis_tdata[58:27] == m_axis_tdata[154:123]))
        else $error("new bar prices differ");

    a_low_le_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[122:91] <= m_axis_tdata[90:59]))
        else $error("bar low above bar high");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/ohlc_front.sv */
// ----------------------------------------------------------------------------
// ohlc_front
// Takes tick requests, holds the session mode and drops out-of-session ticks.
// ----------------------------------------------------------------------------
module ohlc_front
    import ohlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  q_stat_t           q_stat,
    output logic              push,
    output tick_t             push_tick
);

    logic              session_mode_reg;
    logic [TIME_W-1:0] tick_time;
    logic              keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_mode_reg <= MODE_COMMODITY;
        end
        else if (cfg_wen)
        begin
            session_mode_reg <= cfg_wdata;
        end
    end

    assign tick_time = s_axis_tdata[TIME_W-1:0];
    assign keep      = in_session(tick_time, session_mode_reg);

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full && keep;

    assign push_tick.day_number    = s_axis_tdata[38:12];
    assign push_tick.price         = s_axis_tdata[70:39];
    assign push_tick.tick_volume   = s_axis_tdata[102:71];
    assign push_tick.open_interest = s_axis_tdata[134:103];

endmodule

/* hw/rtl/ohlc_queue.sv */
// ----------------------------------------------------------------------------
// ohlc_queue
// Small FIFO of in-session ticks between the front and the bar update.
// ----------------------------------------------------------------------------
module ohlc_queue
    import ohlc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  tick_t   push_tick,
    input  logic    pop,
    output tick_t   pop_tick,
    output q_stat_t q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    tick_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tick;
        end
    end

    assign pop_tick     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == FULL);
    assign q_stat.empty = (count_reg == '0);

endmodule

/* hw/rtl/ohlc_back.sv */
// ----------------------------------------------------------------------------
// ohlc_back
// Daily bar state update; the bar registers double as the output register.
// ----------------------------------------------------------------------------
module ohlc_back
    import ohlc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_stat_t          q_stat,
    input  tick_t            pop_tick,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser
);

    logic               valid_reg,  valid_next;
    logic               new_bar_reg, new_bar_next;
    logic               have_day_reg, have_day_next;
    logic [DAY_W-1:0]   day_reg,    day_next;
    logic [PRICE_W-1:0] open_reg,   open_next;
    logic [PRICE_W-1:0] high_reg,   high_next;
    logic [PRICE_W-1:0] low_reg,    low_next;
    logic [PRICE_W-1:0] close_reg,  close_next;
    logic [SUM_W-1:0]   volume_reg, volume_next;
    logic [OI_W-1:0]    oi_reg,     oi_next;
    logic [SUM_W:0]     vol_sum;
    logic               fresh;

    assign pop     = !q_stat.empty && (!valid_reg || m_axis_tready);
    assign fresh   = !have_day_reg || (pop_tick.day_number != day_reg);
    assign vol_sum = {1'b0, volume_reg} + {{(SUM_W + 1 - VOL_W){1'b0}}, pop_tick.tick_volume};

    always_comb
    begin
        valid_next    = valid_reg;
        new_bar_next  = new_bar_reg;
        have_day_next = have_day_reg;
        day_next      = day_reg;
        open_next     = open_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        close_next    = close_reg;
        volume_next   = volume_reg;
        oi_next       = oi_reg;
        if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next    = 1'b1;
            new_bar_next  = fresh;
            have_day_next = 1'b1;
            close_next    = pop_tick.price;
            oi_next       = pop_tick.open_interest;
            if (fresh)
            begin
                day_next    = pop_tick.day_number;
                open_next   = pop_tick.price;
                high_next   = pop_tick.price;
                low_next    = pop_tick.price;
                volume_next = {{(SUM_W - VOL_W){1'b0}}, pop_tick.tick_volume};
            end
            else
            begin
                if (pop_tick.price > high_reg) high_next = pop_tick.price;
                if (pop_tick.price < low_reg)  low_next  = pop_tick.price;
                // saturate on carry out
                volume_next = vol_sum[SUM_W] ? {SUM_W{1'b1}} : vol_sum[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            new_bar_reg  <= 1'b0;
            have_day_reg <= 1'b0;
            day_reg      <= '0;
            open_reg     <= '0;
            high_reg     <= '0;
            low_reg      <= '0;
            close_reg    <= '0;
            volume_reg   <= '0;
            oi_reg       <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            new_bar_reg  <= new_bar_next;
            have_day_reg <= have_day_next;
            day_reg      <= day_next;
            open_reg     <= open_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            close_reg    <= close_next;
            volume_reg   <= volume_next;
            oi_reg       <= oi_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = new_bar_reg;
    assign m_axis_tdata  = {5'b0, oi_reg, volume_reg, close_reg, low_reg, high_reg,
                            open_reg, day_reg};

endmodule
